// File: design/pedfr_pkg.sv
// shared constants, status codes and control types of the per-event distinct flow recorder
package pedfr_pkg;

    // table geometry
    localparam int EVENT_DEPTH     = 65536;
    localparam int FLOWS_PER_EVENT = 16;
    localparam int IDX_W           = $clog2(EVENT_DEPTH);
    localparam int CNT_W           = $clog2(FLOWS_PER_EVENT + 1);
    localparam int FLOW_W          = 32;
    localparam int EVENT_W         = 32;
    localparam int LEN_W           = 16;
    localparam int LIMIT_W         = 16;
    localparam int ROW_W           = FLOWS_PER_EVENT * FLOW_W + CNT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFE;

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_KNOWN     = 3'd0;
    localparam t_status ST_NEW_EVENT = 3'd1;
    localparam t_status ST_NEW_FLOW  = 3'd2;
    localparam t_status ST_RANGE     = 3'd3;
    localparam t_status ST_SKIPPED   = 3'd4;
    localparam t_status ST_FULL      = 3'd5;
    localparam t_status ST_NO_EVENT  = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic clr_step;   // write one zero row of the clearing sweep
        logic accept;     // capture the input beat and start the row read
        logic finish;     // resolve the item, write back, load the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;   // sweep is at its last row
    } t_sts;

endpackage

// File: design/pedfr_ram.sv
// generic simple dual-port ram with registered read
module pedfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/pedfr_ctrl.sv
// controller: clearing sweep, item sequencing and output beat valid
module pedfr_ctrl
    import pedfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid & ~i_out_ready;
        cmd          = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                // resolve only once the output register is free or being emptied
                cmd.finish = ~r_out_valid | i_out_ready;
                if (cmd.finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// File: design/pedfr_dp.sv
// datapath: event table, flow compare, packet state and counters
module pedfr_dp
    import pedfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_first_of_packet,
    input  logic               i_has_event,
    input  logic [EVENT_W-1:0] i_event_id,
    input  logic [FLOW_W-1:0]  i_flow_id,
    input  logic [LEN_W-1:0]   i_packet_length,
    input  logic [LEN_W-1:0]   i_int_length,
    output t_status            o_status,
    output logic [31:0]        o_packet_total,
    output logic [31:0]        o_event_total,
    output logic [31:0]        o_pair_total,
    output logic [63:0]        o_byte_total,
    output logic [63:0]        o_int_byte_total
);

    logic [LIMIT_W-1:0] r_limit;
    logic [IDX_W-1:0]   r_clr_addr;

    logic               r_first, r_has_ev;
    logic [EVENT_W-1:0] r_ev;
    logic [FLOW_W-1:0]  r_flow;
    logic [LEN_W-1:0]   r_plen, r_ilen;

    logic               r_aborted;
    logic [31:0]        r_pkt_cnt, r_ev_cnt, r_pair_cnt;
    logic [63:0]        r_byte_cnt, r_int_cnt;
    t_status            r_status;

    logic [ROW_W-1:0]   rd_row, new_row, wr_data;
    logic [IDX_W-1:0]   rd_addr, wr_addr;
    logic               wr_en;
    logic [CNT_W-1:0]   cnt;
    logic               any_hit, in_range, abort_eff;
    t_status            status;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // clearing sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == {IDX_W{1'b1}});

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_first  <= i_first_of_packet;
            r_has_ev <= i_has_event;
            r_ev     <= i_event_id;
            r_flow   <= i_flow_id;
            r_plen   <= i_packet_length;
            r_ilen   <= i_int_length;
        end
    end

    // table ram: count in the low bits, flow ids above it
    assign rd_addr = i_cmd.accept ? i_event_id[IDX_W-1:0] : r_ev[IDX_W-1:0];

    pedfr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (EVENT_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_row)
    );

    // compare against the stored ids and build the appended row
    always_comb begin
        cnt     = rd_row[CNT_W-1:0];
        any_hit = 1'b0;
        new_row = rd_row;
        for (int j = 0; j < FLOWS_PER_EVENT; j++) begin
            if ((CNT_W'(j) < cnt) && (rd_row[CNT_W + j*FLOW_W +: FLOW_W] == r_flow)) begin
                any_hit = 1'b1;
            end
            if (CNT_W'(j) == cnt) begin
                new_row[CNT_W + j*FLOW_W +: FLOW_W] = r_flow;
            end
        end
        new_row[CNT_W-1:0] = cnt + 1'b1;
    end

    // item decision
    assign in_range  = (r_ev <= {{(EVENT_W-LIMIT_W){1'b0}}, r_limit})
                     && (r_ev[EVENT_W-1:IDX_W] == '0);
    assign abort_eff = r_aborted & ~r_first;

    always_comb begin
        if (abort_eff) begin
            status = ST_SKIPPED;
        end else if (!r_has_ev) begin
            status = ST_NO_EVENT;
        end else if (!in_range) begin
            status = ST_RANGE;
        end else if (cnt == '0) begin
            status = ST_NEW_EVENT;
        end else if (any_hit) begin
            status = ST_KNOWN;
        end else if (cnt >= CNT_W'(FLOWS_PER_EVENT)) begin
            status = ST_FULL;
        end else begin
            status = ST_NEW_FLOW;
        end
    end

    // table write: zero rows during the sweep, appended row on a new pair
    assign wr_en   = i_cmd.clr_step
                   | (i_cmd.finish & ((status == ST_NEW_EVENT) || (status == ST_NEW_FLOW)));
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : r_ev[IDX_W-1:0];
    assign wr_data = i_cmd.clr_step ? '0 : new_row;

    // packet state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aborted  <= 1'b0;
            r_pkt_cnt  <= '0;
            r_ev_cnt   <= '0;
            r_pair_cnt <= '0;
            r_byte_cnt <= '0;
            r_int_cnt  <= '0;
        end else if (i_cmd.finish) begin
            r_aborted <= abort_eff | (status == ST_RANGE);
            if (r_first) begin
                r_pkt_cnt  <= r_pkt_cnt + 1'b1;
                r_byte_cnt <= r_byte_cnt + {{(64-LEN_W){1'b0}}, r_plen};
                r_int_cnt  <= r_int_cnt + {{(64-LEN_W){1'b0}}, r_ilen};
            end
            if (status == ST_NEW_EVENT) begin
                r_ev_cnt <= r_ev_cnt + 1'b1;
            end
            if ((status == ST_NEW_EVENT) || (status == ST_NEW_FLOW)) begin
                r_pair_cnt <= r_pair_cnt + 1'b1;
            end
        end
    end

    // result status register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= status;
        end
    end

    // counters only move when a new result beat is loaded
    assign o_status         = r_status;
    assign o_packet_total   = r_pkt_cnt;
    assign o_event_total    = r_ev_cnt;
    assign o_pair_total     = r_pair_cnt;
    assign o_byte_total     = r_byte_cnt;
    assign o_int_byte_total = r_int_cnt;

endmodule

// File: design/per_event_distinct_flow_recorder.sv
// top level of the per-event distinct flow recorder
//
// After reset the block sweeps its event table to zero, one row per cycle, over all
// EVENT_DEPTH (65536) rows; input ready stays low during the sweep while limit writes are
// taken. For each input beat the event's row (flow count and up to FLOWS_PER_EVENT flow
// ids) is first read from the single table RAM; then all stored ids are compared in
// parallel, the row is written back and the result beat is loaded. One result beat comes
// out per input beat; its totals are the counter values after that item. The result sits
// in an output register, and a following item waits in its compare step until that
// register is taken.
module per_event_distinct_flow_recorder
    import pedfr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_first_of_packet,
    input  logic               i_has_event,
    input  logic [EVENT_W-1:0] i_event_id,
    input  logic [FLOW_W-1:0]  i_flow_id,
    input  logic [LEN_W-1:0]   i_packet_length,
    input  logic [LEN_W-1:0]   i_int_length,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [31:0]        o_packet_total,
    output logic [31:0]        o_event_total,
    output logic [31:0]        o_pair_total,
    output logic [63:0]        o_byte_total,
    output logic [63:0]        o_int_byte_total
);

    t_cmd cmd;
    t_sts sts;

    // sequencing
    pedfr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // table, compare and counters
    pedfr_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_first_of_packet (i_first_of_packet),
        .i_has_event       (i_has_event),
        .i_event_id        (i_event_id),
        .i_flow_id         (i_flow_id),
        .i_packet_length   (i_packet_length),
        .i_int_length      (i_int_length),
        .o_status          (o_status),
        .o_packet_total    (o_packet_total),
        .o_event_total     (o_event_total),
        .o_pair_total      (o_pair_total),
        .o_byte_total      (o_byte_total),
        .o_int_byte_total  (o_int_byte_total)
    );

endmodule
